// ===== design/rpn_stack_integer_alu_assert.svh =====
// Assertion macros used by the RTL that checks itself.
`ifndef RPN_STACK_INTEGER_ALU_ASSERT_SVH
`define RPN_STACK_INTEGER_ALU_ASSERT_SVH

// same-cycle implication
`define RSIA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/rsia_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rsia_pkg;

   localparam int DATA_WIDTH_DEF  = 32;
   localparam int STACK_DEPTH_DEF = 4;
   localparam int FIELD_WIDTH     = 32;
   localparam int LEVEL_WORDS     = 4;

   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_MUL  = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_YZERO   = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;
   localparam logic [1:0] ST_BADOP   = 2'd3;

   typedef struct packed {
      logic [2:0]                    opcode;
      logic signed [FIELD_WIDTH-1:0] push_value;
   } req_word_type;

   typedef struct packed {
      logic signed [FIELD_WIDTH-1:0] reg_x;
      logic signed [FIELD_WIDTH-1:0] reg_y;
      logic signed [FIELD_WIDTH-1:0] reg_z;
      logic signed [FIELD_WIDTH-1:0] reg_t;
      logic [1:0]                    status;
   } rsp_word_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       finish;
      logic [1:0] status;
   } ctrl_cmd_type;

   typedef struct packed {
      logic x_zero;
      logic y_zero;
   } dp_sts_type;

endpackage

`default_nettype wire

// ===== design/rsia_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsia_ctrl #(
   parameter int DATA_WIDTH = rsia_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [2:0]             req_opcode,
   input  wire rsia_pkg::dp_sts_type   sts,
   output rsia_pkg::ctrl_cmd_type      cmd,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready
);

   localparam int CNT_WIDTH = $clog2(DATA_WIDTH);

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_RUN    = 3'b010,
      S_FINISH = 3'b100
   } ctrl_state_type;

   ctrl_state_type       state_ff, state_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [1:0]           status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      status_in  = status_ff;
      req_ready  = (state_ff == S_IDLE);
      cmd        = '0;
      cmd.status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_WIDTH'(DATA_WIDTH - 1);
               state_in = S_FINISH;
               priority if (req_opcode == rsia_pkg::OP_PUSH) begin
                  status_in = rsia_pkg::ST_OK;
               end else if (req_opcode <= rsia_pkg::OP_DIV && sts.y_zero) begin
                  status_in = rsia_pkg::ST_YZERO;
               end else if (req_opcode == rsia_pkg::OP_DIV && sts.x_zero) begin
                  status_in = rsia_pkg::ST_DIVZERO;
               end else if (req_opcode > rsia_pkg::OP_DIV) begin
                  status_in = rsia_pkg::ST_BADOP;
               end else begin
                  status_in = rsia_pkg::ST_OK;
                  if (req_opcode == rsia_pkg::OP_MUL || req_opcode == rsia_pkg::OP_DIV) begin
                     state_in = S_RUN;
                  end
               end
            end
         end
         S_RUN: begin
            cmd.step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      priority if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         status_ff    <= rsia_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         status_ff    <= status_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rsia_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rsia_datapath #(
   parameter int STACK_DEPTH = rsia_pkg::STACK_DEPTH_DEF,
   parameter int DATA_WIDTH  = rsia_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rsia_pkg::req_word_type req_word,
   input  wire rsia_pkg::ctrl_cmd_type cmd,
   output rsia_pkg::dp_sts_type        sts,
   output rsia_pkg::rsp_word_type      rsp_word
);

   logic [DATA_WIDTH-1:0] level_ff [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] level_in [STACK_DEPTH];
   logic [DATA_WIDTH-1:0] level_new [STACK_DEPTH];
   logic [rsia_pkg::FIELD_WIDTH-1:0] lvl_word [rsia_pkg::LEVEL_WORDS];

   logic [2:0]            op_ff, op_in;
   logic [DATA_WIDTH-1:0] push_ff, push_in;
   logic [DATA_WIDTH:0]   rem_ff, rem_in;
   logic [DATA_WIDTH-1:0] quo_ff, quo_in;
   logic [DATA_WIDTH-1:0] dsr_ff, dsr_in;
   logic                  neg_ff, neg_in;
   rsia_pkg::rsp_word_type rsp_ff, rsp_in;

   logic [DATA_WIDTH-1:0] x, y, mag_x, mag_y, result, prod_sum;
   logic [DATA_WIDTH:0]   rem_sh, diff;

   assign x     = level_ff[0];
   assign y     = level_ff[1];
   assign mag_x = x[DATA_WIDTH-1] ? -x : x;
   assign mag_y = y[DATA_WIDTH-1] ? -y : y;

   assign sts.x_zero = (x == '0);
   assign sts.y_zero = (y == '0);

   assign rem_sh   = {rem_ff[DATA_WIDTH-1:0], quo_ff[DATA_WIDTH-1]};
   assign diff     = rem_sh - {1'b0, dsr_ff};
   assign prod_sum = rem_ff[DATA_WIDTH-1:0] + (quo_ff[0] ? dsr_ff : '0);

   always_comb begin
      op_in   = op_ff;
      push_in = push_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      priority if (cmd.load) begin
         op_in   = req_word.opcode;
         push_in = DATA_WIDTH'(req_word.push_value);
         rem_in  = '0;
         neg_in  = x[DATA_WIDTH-1] ^ y[DATA_WIDTH-1];
         if (req_word.opcode == rsia_pkg::OP_MUL) begin
            quo_in = x;
            dsr_in = y;
         end else begin
            quo_in = mag_y;
            dsr_in = mag_x;
         end
      end else if (cmd.step) begin
         if (op_ff == rsia_pkg::OP_MUL) begin
            rem_in = {1'b0, prod_sum};
            quo_in = quo_ff >> 1;
            dsr_in = dsr_ff << 1;
         end else if (!diff[DATA_WIDTH]) begin
            rem_in = diff;
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DATA_WIDTH-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         rsia_pkg::OP_ADD: result = y + x;
         rsia_pkg::OP_SUB: result = y - x;
         rsia_pkg::OP_MUL: result = rem_ff[DATA_WIDTH-1:0];
         rsia_pkg::OP_DIV: result = neg_ff ? -quo_ff : quo_ff;
         default:          result = '0;
      endcase
   end

   always_comb begin
      if (op_ff == rsia_pkg::OP_PUSH) begin
         level_new[0] = push_ff;
         for (int i = 1; i < STACK_DEPTH; i++) begin
            level_new[i] = level_ff[i-1];
         end
      end else begin
         level_new[0] = result;
         for (int i = 1; i < STACK_DEPTH - 1; i++) begin
            level_new[i] = level_ff[i+1];
         end
         level_new[STACK_DEPTH-1] = '0;
      end
      if (cmd.finish && cmd.status == rsia_pkg::ST_OK) begin
         level_in = level_new;
      end else begin
         level_in = level_ff;
      end
   end

   for (genvar g = 0; g < rsia_pkg::LEVEL_WORDS; g++) begin : g_word
      if (g < STACK_DEPTH) begin : g_level
         assign lvl_word[g] = rsia_pkg::FIELD_WIDTH'($signed(level_in[g]));
      end else begin : g_missing
         assign lvl_word[g] = '0;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.finish) begin
         rsp_in.reg_x  = lvl_word[0];
         rsp_in.reg_y  = lvl_word[1];
         rsp_in.reg_z  = lvl_word[2];
         rsp_in.reg_t  = lvl_word[3];
         rsp_in.status = cmd.status;
      end
   end

   assign rsp_word = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < STACK_DEPTH; i++) begin
            level_ff[i] <= '0;
         end
      end else begin
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      push_ff <= push_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsr_ff  <= dsr_in;
      neg_ff  <= neg_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

// ===== design/rpn_stack_integer_alu.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Every accepted word is loaded, then written to the result register in the finish state once
// that register is free. Multiply and divide that are not refused first pass through the run state:
// the shift-add multiply and restoring divide share one loop that handles one bit per cycle.
// One word is worked at a time; the next is taken once the result register is loaded.
// Synchronous active-high reset clears all stack levels to zero and empties the result register.
`include "rpn_stack_integer_alu_assert.svh"

module rpn_stack_integer_alu #(
   parameter int STACK_DEPTH = rsia_pkg::STACK_DEPTH_DEF,
   parameter int DATA_WIDTH  = rsia_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rsia_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rsia_pkg::rsp_word_type      rsp_word
);

   rsia_pkg::ctrl_cmd_type cmd;
   rsia_pkg::dp_sts_type   sts;
   logic                   busy;
   logic                   push_fire;

   rsia_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_word.opcode),
      .sts        (sts),
      .cmd        (cmd),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready)
   );

   rsia_datapath #(
      .STACK_DEPTH (STACK_DEPTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_word (rsp_word)
   );

   assign busy      = cmd.step || cmd.finish;
   assign push_fire = req_valid && req_ready && (req_word.opcode == rsia_pkg::OP_PUSH);

   `RSIA_ASSERT_NEXT(a_finish_shows_word, clock, reset, cmd.finish, rsp_valid, "no result shown")
   `RSIA_ASSERT_NOW(a_busy_blocks_accept, clock, reset, busy, !req_ready, "accept while busy")
   `RSIA_ASSERT_NEXT(a_push_no_iteration, clock, reset, push_fire, !cmd.step, "push iterated")

endmodule

`default_nettype wire
